### src/spectral_accumulator_macros.svh
// Assertion macros for the checker of the spectral accumulator.
// Holds macro definitions only; included by the checker file.
`ifndef SPECTRAL_ACCUMULATOR_MACROS_SVH
`define SPECTRAL_ACCUMULATOR_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define SA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/spec_acc_pkg.sv
// Package for the spectral accumulator: field widths, register indexes and defaults.
// No dependencies; imported by the top level and its checker.
package spec_acc_pkg;

    localparam int SA_NUM_BINS   = 4096;
    localparam int SA_BIN_W      = 12;
    localparam int SA_VAL_W      = 24;
    localparam int SA_MSCALE_W   = 17;
    localparam int SA_GLISS_W    = 18;
    localparam int SA_END_W      = 13;
    localparam int SA_CFG_IDX_W  = 3;
    localparam int SA_CFG_DATA_W = 24;

    localparam logic [SA_CFG_IDX_W-1:0] CFG_MAG_SCALE   = 3'd0;
    localparam logic [SA_CFG_IDX_W-1:0] CFG_GLISS       = 3'd1;
    localparam logic [SA_CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd2;
    localparam logic [SA_CFG_IDX_W-1:0] CFG_GATE        = 3'd3;
    localparam logic [SA_CFG_IDX_W-1:0] CFG_NYQUIST     = 3'd4;
    localparam logic [SA_CFG_IDX_W-1:0] CFG_IMPLODE     = 3'd5;
    localparam logic [SA_CFG_IDX_W-1:0] CFG_RANGE_LOW   = 3'd6;
    localparam logic [SA_CFG_IDX_W-1:0] CFG_RANGE_END   = 3'd7;

    localparam logic [SA_MSCALE_W-1:0] RST_MAG_SCALE = 17'd65536;
    localparam logic [SA_GLISS_W-1:0]  RST_GLISS     = 18'd65536;
    localparam logic [SA_VAL_W-1:0]    RST_NYQUIST   = 24'hFFFFFF;
    localparam logic [SA_END_W-1:0]    RST_RANGE_END = 13'd4096;

endpackage

### src/spec_acc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-first behavior on a same-address access; no dependencies.
module spec_acc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/spectral_accumulator.sv
// Channel  | valid       | stall       | payload
// input    | i_in_valid  | o_in_stall  | i_bin_index, i_amplitude_in, i_frequency_in
// output   | o_out_valid | i_out_stall | o_amplitude_out, o_frequency_out
// One item per cycle unless the input stalls; a result passes stage 1, stage 2 and the
// output queue. An item whose bin equals that of the item in stage 1 stalls until that
// item moves on, since the RAM read, two-stage scaling and write-back form the loop.
// After reset a clearing pass writes zero to all NUM_BINS entries, one per cycle, and no
// item is accepted until it ends. A four-entry output queue absorbs downstream stalls;
// the input stalls when queued and in-flight items fill it and no result is taken.
// Depends on spec_acc_pkg and spec_acc_ram.
module spectral_accumulator
    import spec_acc_pkg::*;
#(
    parameter int NUM_BINS = SA_NUM_BINS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SA_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SA_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [SA_BIN_W-1:0]      i_bin_index,
    input  logic [SA_VAL_W-1:0]      i_amplitude_in,
    input  logic [SA_VAL_W-1:0]      i_frequency_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [SA_VAL_W-1:0]      o_amplitude_out,
    output logic [SA_VAL_W-1:0]      o_frequency_out
);

    localparam int AW     = $clog2(NUM_BINS);
    localparam int MW     = 2 * SA_VAL_W;
    localparam int OQ_D   = 4;
    localparam int OQ_AW  = $clog2(OQ_D);
    localparam int PM_W   = SA_VAL_W + SA_MSCALE_W;
    localparam int PF_W   = SA_VAL_W + SA_GLISS_W;

    // Configuration registers.
    logic [SA_MSCALE_W-1:0] r_mag_scale;
    logic [SA_GLISS_W-1:0]  r_gliss;
    logic [SA_VAL_W-1:0]    r_thresh;
    logic [SA_VAL_W-1:0]    r_gate;
    logic [SA_VAL_W-1:0]    r_nyq;
    logic                   r_implode;
    logic [SA_BIN_W-1:0]    r_low;
    logic [SA_END_W-1:0]    r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_scale <= RST_MAG_SCALE;
            r_gliss     <= RST_GLISS;
            r_thresh    <= '0;
            r_gate      <= '0;
            r_nyq       <= RST_NYQUIST;
            r_implode   <= 1'b1;
            r_low       <= '0;
            r_end       <= RST_RANGE_END;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAG_SCALE: r_mag_scale <= i_cfg_data[SA_MSCALE_W-1:0];
                CFG_GLISS:     r_gliss     <= i_cfg_data[SA_GLISS_W-1:0];
                CFG_THRESHOLD: r_thresh    <= i_cfg_data;
                CFG_GATE:      r_gate      <= i_cfg_data;
                CFG_NYQUIST:   r_nyq       <= i_cfg_data;
                CFG_IMPLODE:   r_implode   <= i_cfg_data[0];
                CFG_RANGE_LOW: r_low       <= i_cfg_data[SA_BIN_W-1:0];
                CFG_RANGE_END: r_end       <= i_cfg_data[SA_END_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clearing pass.
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(NUM_BINS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Pipeline and queue control.
    logic                r_s1_valid, r_s1_inr;
    logic [SA_BIN_W-1:0] r_s1_bin;
    logic [SA_VAL_W-1:0] r_s1_amp, r_s1_frq;
    logic                r_s2_valid, r_s2_inr;
    logic [SA_BIN_W-1:0] r_s2_bin;
    logic [SA_VAL_W-1:0] r_s2_amp, r_s2_frq;
    logic [PM_W-1:0]     r_s2_pmag;
    logic [PF_W-1:0]     r_s2_pfrq;
    logic [OQ_AW:0]      r_oq_cnt;
    logic [OQ_AW-1:0]    r_oq_wp, r_oq_rp;
    logic [SA_VAL_W-1:0] r_oq_amp [OQ_D];
    logic [SA_VAL_W-1:0] r_oq_frq [OQ_D];

    logic            in_inr, hazard, room, accept, pop;
    logic [OQ_AW+1:0] occ;
    logic [31:0]     in_bin_ext, s2_bin_ext;

    assign in_bin_ext = 32'(i_bin_index);
    assign in_inr     = in_bin_ext < 32'(NUM_BINS);
    assign hazard     = r_s1_valid && r_s1_inr && in_inr && (r_s1_bin == i_bin_index);
    assign pop        = o_out_valid && !i_out_stall;
    assign occ        = (OQ_AW+2)'(r_oq_cnt) + (OQ_AW+2)'(r_s1_valid)
                        + (OQ_AW+2)'(r_s2_valid);
    assign room       = (occ < (OQ_AW+2)'(OQ_D)) || pop;
    assign o_in_stall = r_clr_busy || !room || hazard;
    assign accept     = i_in_valid && !o_in_stall;

    // Accumulator RAM and forwarding of the most recent write.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [MW-1:0] ram_wdata, ram_rdata;
    logic          s2_we;
    logic [MW-1:0] s2_wdata;

    spec_acc_ram #(
        .WIDTH(MW),
        .DEPTH(NUM_BINS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(in_bin_ext[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign s2_bin_ext = 32'(r_s2_bin);
    assign ram_we     = r_clr_busy || s2_we;
    assign ram_waddr  = r_clr_busy ? r_clr_addr : s2_bin_ext[AW-1:0];
    assign ram_wdata  = r_clr_busy ? '0 : s2_wdata;

    logic                r_fw_valid;
    logic [SA_BIN_W-1:0] r_fw_bin;
    logic [MW-1:0]       r_fw_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (s2_we) begin
            r_fw_valid <= 1'b1;
        end
        if (s2_we) begin
            r_fw_bin  <= r_s2_bin;
            r_fw_data <= s2_wdata;
        end
    end

    // Stage 1: pick the current entry and multiply.
    logic [MW-1:0]   acc;
    logic [PM_W-1:0] n_pmag;
    logic [PF_W-1:0] n_pfrq;

    assign acc    = (r_fw_valid && r_fw_bin == r_s1_bin) ? r_fw_data : ram_rdata;
    assign n_pmag = PM_W'(acc[MW-1:SA_VAL_W]) * PM_W'(r_mag_scale);
    assign n_pfrq = PF_W'(acc[SA_VAL_W-1:0]) * PF_W'(r_gliss);

    // Stage 2: round, saturate and decide.
    logic [PM_W:0]       mag_rnd;
    logic [PF_W:0]       frq_rnd;
    logic [SA_VAL_W-1:0] mag_scl, frq_scl, new_mag, new_frq, out_amp, out_frq;
    logic                gate_open, below, restart, in_rng;

    always_comb begin
        mag_rnd   = {1'b0, r_s2_pmag} + (PM_W+1)'(32768);
        frq_rnd   = {1'b0, r_s2_pfrq} + (PF_W+1)'(32768);
        mag_scl   = (|mag_rnd[PM_W:SA_VAL_W+16]) ? '1 : mag_rnd[SA_VAL_W+15:16];
        frq_scl   = (|frq_rnd[PF_W:SA_VAL_W+16]) ? '1 : frq_rnd[SA_VAL_W+15:16];
        gate_open = r_s2_amp >= r_gate;
        below     = mag_scl < r_thresh;
        restart   = (r_s2_amp > mag_scl) || (below == r_implode) || (frq_scl > r_nyq);
        in_rng    = (r_s2_bin >= r_low) && ({1'b0, r_s2_bin} < r_end);
        new_mag   = mag_scl;
        new_frq   = frq_scl;
        out_amp   = r_s2_amp;
        out_frq   = r_s2_frq;
        if (gate_open && restart) begin
            new_mag = r_s2_amp;
            new_frq = r_s2_frq;
        end else if (gate_open && in_rng && r_s2_inr) begin
            out_amp = mag_scl;
            out_frq = frq_scl;
        end
    end

    assign s2_we    = r_s2_valid && r_s2_inr;
    assign s2_wdata = {new_mag, new_frq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_inr  <= in_inr;
        r_s1_bin  <= i_bin_index;
        r_s1_amp  <= i_amplitude_in;
        r_s1_frq  <= i_frequency_in;
        r_s2_inr  <= r_s1_inr;
        r_s2_bin  <= r_s1_bin;
        r_s2_amp  <= r_s1_amp;
        r_s2_frq  <= r_s1_frq;
        r_s2_pmag <= n_pmag;
        r_s2_pfrq <= n_pfrq;
    end

    // Output queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_cnt <= '0;
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
        end else begin
            r_oq_cnt <= r_oq_cnt + (OQ_AW+1)'(r_s2_valid) - (OQ_AW+1)'(pop);
            if (r_s2_valid) begin
                r_oq_wp <= r_oq_wp + OQ_AW'(1);
            end
            if (pop) begin
                r_oq_rp <= r_oq_rp + OQ_AW'(1);
            end
        end
        if (r_s2_valid) begin
            r_oq_amp[r_oq_wp] <= out_amp;
            r_oq_frq[r_oq_wp] <= out_frq;
        end
    end

    assign o_out_valid     = r_oq_cnt != '0;
    assign o_amplitude_out = r_oq_amp[r_oq_rp];
    assign o_frequency_out = r_oq_frq[r_oq_rp];

endmodule

### src/spec_acc_chk.sv
// Port-level checker for the spectral accumulator, bound to the top level.
// Depends on spec_acc_pkg and spectral_accumulator_macros.svh.
`include "spectral_accumulator_macros.svh"

module spec_acc_chk
    import spec_acc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [SA_VAL_W-1:0]      o_amplitude_out,
    input logic [SA_VAL_W-1:0]      o_frequency_out
);

    // The clearing pass holds off items right after reset.
    `SA_ASSERT_ALWAYS(a_stall_after_reset, !i_rst_n |=> o_in_stall,
        "input not stalled after reset")

    // A result only appears after an accepted item has passed stage 1, stage 2 and the queue.
    `SA_ASSERT(a_rise_needs_item, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 3),
        "result appeared without a matching item")

    `SA_ASSERT(a_out_valid_holds, o_out_valid && i_out_stall |=> o_out_valid,
        "stalled result withdrawn")

    `SA_ASSERT(a_out_data_holds,
        o_out_valid && i_out_stall |=> $stable(o_amplitude_out) && $stable(o_frequency_out),
        "stalled result changed")

endmodule

bind spectral_accumulator spec_acc_chk u_spec_acc_chk (.*);

### test/spectral_accumulator_tb.sv
// Self-checking testbench for spectral_accumulator: directed bins, then random register settings.
// Each item is checked against a bit-exact per-bin accumulator predictor kept here.
// Depends on spec_acc_pkg and the spectral_accumulator RTL.
module spectral_accumulator_tb
    import spec_acc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 500;
    localparam int PHASE_ITEMS   = 60;
    localparam int MAX_REPORTS   = 10;
    localparam logic [SA_VAL_W-1:0] VAL_MAX = {SA_VAL_W{1'b1}};

    typedef struct packed {
        logic [SA_BIN_W-1:0] bin;
        logic [SA_VAL_W-1:0] amp;
        logic [SA_VAL_W-1:0] freq;
    } bin_item_t;

    typedef struct packed {
        logic [SA_VAL_W-1:0] amp;
        logic [SA_VAL_W-1:0] freq;
    } bin_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [SA_CFG_IDX_W-1:0] cfg_index = '0;
    logic [SA_CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [SA_BIN_W-1:0] in_bin = '0;
    logic [SA_VAL_W-1:0] in_amp = '0;
    logic [SA_VAL_W-1:0] in_freq = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [SA_VAL_W-1:0] out_amp;
    logic [SA_VAL_W-1:0] out_freq;

    logic [SA_MSCALE_W-1:0] mag_scale = RST_MAG_SCALE;
    logic [SA_GLISS_W-1:0] gliss = RST_GLISS;
    logic [SA_VAL_W-1:0] threshold = '0;
    logic [SA_VAL_W-1:0] gate = '0;
    logic [SA_VAL_W-1:0] nyquist = RST_NYQUIST;
    logic implode = 1'b1;
    logic [SA_BIN_W-1:0] range_low = '0;
    logic [SA_END_W-1:0] range_end = RST_RANGE_END;

    logic [SA_VAL_W-1:0] acc_mag [SA_NUM_BINS];
    logic [SA_VAL_W-1:0] acc_freq [SA_NUM_BINS];

    bin_item_t pending_bins[$];
    bin_result_t expected_bins[$];

    logic in_hit = 1'b0;
    logic out_hit = 1'b0;
    bit in_idle_en = 1'b1;
    bit out_idle_en = 1'b1;
    int in_gap = 0;
    int out_wait = 0;
    int cycle_count = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_replaced = 0;
    int n_settings = 0;

    spectral_accumulator dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_bin_index    (in_bin),
        .i_amplitude_in (in_amp),
        .i_frequency_in (in_freq),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_amplitude_out(out_amp),
        .o_frequency_out(out_freq)
    );

    always #2 clk = ~clk;

    function automatic logic [SA_VAL_W-1:0] scale_sat(logic [SA_VAL_W-1:0] v,
                                                      logic [SA_GLISS_W-1:0] f);
        logic [63:0] p;
        p = ({40'd0, v} * {46'd0, f} + 64'd32768) >> 16;
        return (p > {40'd0, VAL_MAX}) ? VAL_MAX : p[SA_VAL_W-1:0];
    endfunction

    function automatic bin_result_t accumulate_bin(bin_item_t it);
        logic [SA_VAL_W-1:0] mag;
        logic [SA_VAL_W-1:0] fr;
        logic below;
        bin_result_t r;
        r.amp = it.amp;
        r.freq = it.freq;
        mag = scale_sat(acc_mag[it.bin], {1'b0, mag_scale});
        fr = scale_sat(acc_freq[it.bin], gliss);
        if (it.amp >= gate) begin
            below = (mag < threshold);
            if (it.amp > mag || below == implode || fr > nyquist) begin
                mag = it.amp;
                fr = it.freq;
            end else if (it.bin >= range_low && {1'b0, it.bin} < range_end) begin
                r.amp = mag;
                r.freq = fr;
                n_replaced++;
            end
        end
        acc_mag[it.bin] = mag;
        acc_freq[it.bin] = fr;
        return r;
    endfunction

    function automatic int draw_wait(bit en);
        return en ? int'($urandom_range(0, 8)) : 0;
    endfunction

    // Driver: presents queued items and the downstream stall, both on the falling edge.
    always @(negedge clk) begin : drive
        bin_item_t item;
        if (!(in_valid && !in_hit)) begin
            if (pending_bins.size() == 0) begin
                in_valid <= 1'b0;
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else begin
                item = pending_bins.pop_front();
                in_bin <= item.bin;
                in_amp <= item.amp;
                in_freq <= item.freq;
                in_valid <= 1'b1;
                if ($urandom_range(0, 31) == 0) in_idle_en = !in_idle_en;
                in_gap = draw_wait(in_idle_en);
            end
        end
        if (out_hit) begin
            if ($urandom_range(0, 31) == 0) out_idle_en = !out_idle_en;
            out_wait = draw_wait(out_idle_en);
        end
        if (out_wait > 0) begin
            out_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: predicts on each accepted item and checks each accepted result.
    always @(posedge clk) begin : watch
        bin_result_t exp_r;
        cycle_count++;
        in_hit <= rst_n && in_valid && !in_stall;
        out_hit <= rst_n && out_valid && !out_stall;
        if (rst_n && in_valid && !in_stall) begin
            expected_bins.push_back(accumulate_bin('{in_bin, in_amp, in_freq}));
            n_accepted++;
        end
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (expected_bins.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("ERROR: unexpected result amp=%h freq=%h", out_amp, out_freq);
            end else begin
                exp_r = expected_bins.pop_front();
                if (out_amp !== exp_r.amp || out_freq !== exp_r.freq) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("ERROR: result %0d amp exp %h got %h, freq exp %h got %h",
                                 n_results, exp_r.amp, out_amp, exp_r.freq, out_freq);
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_item(input logic [SA_BIN_W-1:0] bin, input logic [SA_VAL_W-1:0] amp,
                            input logic [SA_VAL_W-1:0] freq);
        pending_bins.push_back('{bin, amp, freq});
    endtask

    task automatic settle();
        while (pending_bins.size() != 0 || in_valid || expected_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [SA_CFG_IDX_W-1:0] idx,
                             input logic [SA_CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAG_SCALE: mag_scale = val[SA_MSCALE_W-1:0];
            CFG_GLISS:     gliss = val[SA_GLISS_W-1:0];
            CFG_THRESHOLD: threshold = val;
            CFG_GATE:      gate = val;
            CFG_NYQUIST:   nyquist = val;
            CFG_IMPLODE:   implode = val[0];
            CFG_RANGE_LOW: range_low = val[SA_BIN_W-1:0];
            CFG_RANGE_END: range_end = val[SA_END_W-1:0];
            default: ;
        endcase
    endtask

    function automatic int unsigned pick(int unsigned lo, int unsigned hi,
                                         int unsigned typ_lo, int unsigned typ_hi);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(typ_lo, typ_hi);
    endfunction

    task automatic write_random_config();
        logic mode;
        mode = 1'($urandom_range(0, 1));
        write_reg(CFG_MAG_SCALE, SA_CFG_DATA_W'(pick(0, 131071, 45000, 70000)));
        write_reg(CFG_GLISS, SA_CFG_DATA_W'(pick(0, 262143, 50000, 80000)));
        write_reg(CFG_GATE, SA_CFG_DATA_W'(pick(0, VAL_MAX, 0, 'h1000)));
        write_reg(CFG_NYQUIST, SA_CFG_DATA_W'(pick(0, VAL_MAX, 'h800000, VAL_MAX)));
        write_reg(CFG_IMPLODE, SA_CFG_DATA_W'(mode));
        if (mode)
            write_reg(CFG_THRESHOLD, SA_CFG_DATA_W'(pick(0, VAL_MAX, 0, 'h1000)));
        else
            write_reg(CFG_THRESHOLD, SA_CFG_DATA_W'(pick(0, VAL_MAX, 'hF00000, VAL_MAX)));
        write_reg(CFG_RANGE_LOW, SA_CFG_DATA_W'(pick(0, 4095, 0, 24)));
        write_reg(CFG_RANGE_END, SA_CFG_DATA_W'(pick(0, 4096, 8, 4096)));
        n_settings++;
    endtask

    function automatic logic [SA_BIN_W-1:0] pick_bin();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return SA_BIN_W'(SA_NUM_BINS - 1);
        if (r == 1) return SA_BIN_W'($urandom_range(0, SA_NUM_BINS - 1));
        return SA_BIN_W'($urandom_range(0, 31));
    endfunction

    initial begin
        int n_random;
        int phase_items;
        int len;
        logic [SA_BIN_W-1:0] bin;
        logic [SA_VAL_W-1:0] loud;

        foreach (acc_mag[i]) begin
            acc_mag[i] = '0;
            acc_freq[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero entries, full-scale bins, equal amplitude holds.
        n_settings = 1;
        add_item(0, 0, 0);
        add_item(SA_NUM_BINS - 1, VAL_MAX, VAL_MAX);
        add_item(SA_NUM_BINS - 1, 'h800000, 'h123456);
        add_item(5, 1000, 'h00AA00);
        add_item(5, 1000, 'h00AA01);
        add_item(5, 1001, 'h000001);
        settle();

        // Maximum growth and glissando, gate, Nyquist restart, hold in and out of range.
        write_reg(CFG_MAG_SCALE, 131071);
        write_reg(CFG_GLISS, 262143);
        write_reg(CFG_GATE, 'h100);
        write_reg(CFG_NYQUIST, 'h800000);
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_IMPLODE, 1);
        write_reg(CFG_RANGE_LOW, 4);
        write_reg(CFG_RANGE_END, 8);
        n_settings++;
        add_item(4, 'h900000, 'h100000);
        add_item(4, 'h10, 'h000020);
        add_item(4, 'h200, 'h000001);
        add_item(4, 'h100, 'h000002);
        add_item(9, 'h5000, 'h000100);
        add_item(9, 'h100, 'h000100);
        add_item(7, 'h0FF, 'h000300);
        settle();

        // Explode sense with an empty output range, then explode restart and a full gate.
        write_reg(CFG_MAG_SCALE, 65536);
        write_reg(CFG_GLISS, 0);
        write_reg(CFG_GATE, 0);
        write_reg(CFG_NYQUIST, VAL_MAX);
        write_reg(CFG_THRESHOLD, VAL_MAX);
        write_reg(CFG_IMPLODE, 0);
        write_reg(CFG_RANGE_LOW, 4095);
        write_reg(CFG_RANGE_END, 0);
        n_settings++;
        add_item(20, 'h300000, 'h001234);
        add_item(20, 'h100000, 'h005678);
        settle();
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_RANGE_LOW, 0);
        write_reg(CFG_RANGE_END, 4096);
        n_settings++;
        add_item(20, 'h50, 'h000777);
        add_item(20, 'h40, 'h000778);
        settle();
        write_reg(CFG_GATE, VAL_MAX);
        n_settings++;
        add_item(20, VAL_MAX - 1, 'hABCDEF);
        add_item(21, VAL_MAX, 'hFEDCBA);
        settle();

        // Random part: mostly runs of items on one bin that start loud, plus raw noise.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            write_random_config();
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_item(SA_BIN_W'($urandom), SA_VAL_W'($urandom), SA_VAL_W'($urandom));
                    phase_items++;
                end else begin
                    bin = pick_bin();
                    len = int'($urandom_range(2, 6));
                    loud = SA_VAL_W'($urandom_range('h400000, VAL_MAX));
                    add_item(bin, loud, SA_VAL_W'($urandom_range(0, 'h7FFFFF)));
                    for (int k = 1; k < len; k++)
                        add_item(bin, SA_VAL_W'($urandom_range(0, loud)),
                                 SA_VAL_W'($urandom_range(0, 'h7FFFFF)));
                    phase_items += len;
                end
            end
            n_random += phase_items;
            settle();
        end

        $display("Ran %0d items and checked %0d results under %0d register settings.",
                 n_accepted, n_results, n_settings);
        $display("%0d results came from the accumulator; %0d mismatches.",
                 n_replaced, n_errors);
        if (n_errors == 0 && expected_bins.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
